[src/qmci_pkg.sv]
// Shared types, constants and a helper function for the quadtree Morton cell index block.
// Used by qmci_cell_map, qmci_index and quadtree_morton_cell_index_core.
package qmci_pkg;

  localparam int COORD_W    = 24;
  localparam int DIFF_W     = 25;
  localparam int INV_W      = 24;
  localparam int PROD_W     = 48;
  localparam int FRAC_W     = 24;
  localparam int INDEX_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int SPREAD_IN  = 8;
  localparam int SPREAD_OUT = 16;

  localparam logic [INV_W-1:0]   INV_RESET      = 24'h010000;
  localparam logic [INDEX_W-1:0] OFFSET_PATTERN = 15'h5555;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_INV_W    = 2'd2,
    CFG_INV_H    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [INDEX_W-1:0] cell_index;
    logic               out_of_range;
  } result_t;

  // Places bit i of the input at bit 2*i of the result.
  function automatic logic [SPREAD_OUT-1:0] spread_bits(input logic [SPREAD_IN-1:0] n);
    logic [SPREAD_OUT-1:0] r;
    r = '0;
    for (int i = 0; i < SPREAD_IN; i++) begin
      r[2*i] = n[i];
    end
    return r;
  endfunction

endpackage

[src/quadtree_morton_cell_index_core.sv]
// Top level of the linear quadtree Morton cell index block: configuration, pipeline control.
// Depends on qmci_pkg, qmci_cell_map and qmci_index.
//
// Each input word carries one box and produces exactly one result word. The block accepts a
// word in every cycle while its input register is empty or its result register can advance.
// The input register holds the origin-relative corner coordinates, and the cell mapping (one
// 24 by 24 bit multiply per corner), Morton interleave, level search and index offset are
// computed between that register and the result register. A result waiting on the output
// does not block an empty input register from taking the next word. A corner left of or
// above the origin, or at or beyond the edge of the finest grid, gives out_of_range set and
// a cell index of 0. The reciprocals are applied after the input register, so the user must
// ensure configuration is written only while no word is in flight; the block does not check.
module quadtree_morton_cell_index_core
  import qmci_pkg::*;
#(
  parameter int TREE_DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // Fields from bit 0: box_left[23:0], box_top[47:24], box_right[71:48], box_bottom[95:72].
  input  logic [95:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // Fields from bit 0: cell_index[14:0], out_of_range[15].
  output logic [15:0]          m_axis_tdata
);

  localparam int FINEST = TREE_DEPTH - 1;
  localparam int CELL_W = (FINEST > 0) ? FINEST : 1;
  localparam logic [INDEX_W-1:0] INDEX_MAX =
    INDEX_W'((((64'd1 << (2 * TREE_DEPTH)) - 64'd1) / 64'd3) - 64'd1);

  logic signed [COORD_W-1:0] origin_x_q;
  logic signed [COORD_W-1:0] origin_y_q;
  logic        [INV_W-1:0]   inv_w_q;
  logic        [INV_W-1:0]   inv_h_q;

  logic signed [COORD_W-1:0] box_left;
  logic signed [COORD_W-1:0] box_top;
  logic signed [COORD_W-1:0] box_right;
  logic signed [COORD_W-1:0] box_bottom;

  logic signed [DIFF_W-1:0] dl_d, dt_d, dr_d, db_d;
  logic signed [DIFF_W-1:0] dl_q, dt_q, dr_q, db_q;
  logic                     s1_valid_d, s1_valid_q;
  logic                     out_valid_d, out_valid_q;
  result_t                  out_q;
  result_t                  result;

  logic              accept;
  logic              adv_out;
  logic [CELL_W-1:0] lx, ty, rx, by;
  logic              ok_l, ok_t, ok_r, ok_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      inv_w_q    <= INV_RESET;
      inv_h_q    <= INV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        CFG_INV_W:    inv_w_q    <= cfg_data_i;
        CFG_INV_H:    inv_h_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign box_left   = s_axis_tdata[23:0];
  assign box_top    = s_axis_tdata[47:24];
  assign box_right  = s_axis_tdata[71:48];
  assign box_bottom = s_axis_tdata[95:72];

  assign dl_d = DIFF_W'(box_left)   - DIFF_W'(origin_x_q);
  assign dt_d = DIFF_W'(box_top)    - DIFF_W'(origin_y_q);
  assign dr_d = DIFF_W'(box_right)  - DIFF_W'(origin_x_q);
  assign db_d = DIFF_W'(box_bottom) - DIFF_W'(origin_y_q);

  assign adv_out       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv_out;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv_out) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = adv_out ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dl_q <= dl_d;
      dt_q <= dt_d;
      dr_q <= dr_d;
      db_q <= db_d;
    end
    if (adv_out && s1_valid_q) begin
      out_q <= result;
    end
  end

  qmci_cell_map #(.FINEST(FINEST), .CELL_W(CELL_W)) u_map_left (
    .diff_i(dl_q), .inv_i(inv_w_q), .cell_o(lx), .in_range_o(ok_l)
  );
  qmci_cell_map #(.FINEST(FINEST), .CELL_W(CELL_W)) u_map_top (
    .diff_i(dt_q), .inv_i(inv_h_q), .cell_o(ty), .in_range_o(ok_t)
  );
  qmci_cell_map #(.FINEST(FINEST), .CELL_W(CELL_W)) u_map_right (
    .diff_i(dr_q), .inv_i(inv_w_q), .cell_o(rx), .in_range_o(ok_r)
  );
  qmci_cell_map #(.FINEST(FINEST), .CELL_W(CELL_W)) u_map_bottom (
    .diff_i(db_q), .inv_i(inv_h_q), .cell_o(by), .in_range_o(ok_b)
  );

  qmci_index #(.FINEST(FINEST), .CELL_W(CELL_W)) u_index (
    .in_range_i(ok_l && ok_t && ok_r && ok_b),
    .lx_i(lx),
    .ty_i(ty),
    .rx_i(rx),
    .by_i(by),
    .result_o(result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.out_of_range, out_q.cell_index};

`ifndef SYNTH
  a_oor_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.out_of_range) |-> (out_q.cell_index == '0))
    else $error("out-of-range word carries a nonzero cell index");

  a_index_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.out_of_range) |-> (out_q.cell_index <= INDEX_MAX))
    else $error("cell index beyond the last cell of the tree");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input word taken while both stages are held");

  a_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && adv_out) |=> out_valid_q)
    else $error("word in the input register was not moved to the output");
`endif

endmodule

[src/qmci_cell_map.sv]
// Maps one origin-relative coordinate to a finest-level grid cell with a range check.
// Depends on qmci_pkg for the fixed-point widths.
module qmci_cell_map
  import qmci_pkg::*;
#(
  parameter int FINEST = 7,
  parameter int CELL_W = 7
) (
  input  logic signed [DIFF_W-1:0] diff_i,
  input  logic        [INV_W-1:0]  inv_i,
  output logic        [CELL_W-1:0] cell_o,
  output logic                     in_range_o
);

  logic [PROD_W-1:0] prod;

  assign prod       = diff_i[COORD_W-1:0] * inv_i;
  assign in_range_o = !diff_i[DIFF_W-1] && (prod[PROD_W-1:FRAC_W+FINEST] == '0);
  assign cell_o     = prod[FRAC_W +: CELL_W];

endmodule

[src/qmci_index.sv]
// Interleaves the corner cells into Morton codes, finds the tree level and forms the index.
// Depends on qmci_pkg for the result type and the bit spreading function.
module qmci_index
  import qmci_pkg::*;
#(
  parameter int FINEST = 7,
  parameter int CELL_W = 7
) (
  input  logic              in_range_i,
  input  logic [CELL_W-1:0] lx_i,
  input  logic [CELL_W-1:0] ty_i,
  input  logic [CELL_W-1:0] rx_i,
  input  logic [CELL_W-1:0] by_i,
  output result_t           result_o
);

  localparam int MORTON_W = 2 * CELL_W;
  localparam int LVL_W    = $clog2(CELL_W + 1);

  logic [SPREAD_OUT-1:0] lt_full;
  logic [SPREAD_OUT-1:0] rb_full;
  logic [MORTON_W-1:0]   lt;
  logic [MORTON_W-1:0]   rb;
  logic [MORTON_W-1:0]   code_diff;
  logic [LVL_W-1:0]      level;
  logic [LVL_W-1:0]      level_rem;
  logic [MORTON_W-1:0]   shifted;
  logic [SPREAD_OUT-1:0] offset_mask;
  logic [INDEX_W-1:0]    offset;
  logic [INDEX_W-1:0]    index;

  assign lt_full   = spread_bits(SPREAD_IN'(lx_i)) | (spread_bits(SPREAD_IN'(ty_i)) << 1);
  assign rb_full   = spread_bits(SPREAD_IN'(rx_i)) | (spread_bits(SPREAD_IN'(by_i)) << 1);
  assign lt        = lt_full[MORTON_W-1:0];
  assign rb        = rb_full[MORTON_W-1:0];
  assign code_diff = lt ^ rb;

  // The level is one above the highest two-bit group where the corner codes differ.
  always_comb begin
    level = '0;
    for (int i = 0; i < FINEST; i++) begin
      if (code_diff[2*i +: 2] != 2'b00) begin
        level = LVL_W'(i + 1);
      end
    end
  end

  assign level_rem   = LVL_W'(FINEST) - level;
  assign shifted     = rb >> {level, 1'b0};
  assign offset_mask = (SPREAD_OUT'(1) << {level_rem, 1'b0}) - SPREAD_OUT'(1);
  assign offset      = offset_mask[INDEX_W-1:0] & OFFSET_PATTERN;
  assign index       = INDEX_W'(shifted) + offset;

  always_comb begin
    if (in_range_i) begin
      result_o.cell_index   = index;
      result_o.out_of_range = 1'b0;
    end else begin
      result_o.cell_index   = '0;
      result_o.out_of_range = 1'b1;
    end
  end

endmodule

[sim/tb.sv]
// Self-checking testbench for quadtree_morton_cell_index_core: boxes are streamed in and every
// result word is checked against a fixed-point cell index predictor kept in this file.
// Depends on qmci_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;
  import qmci_pkg::*;

  localparam int TREE_DEPTH  = 8;
  localparam int FINEST      = TREE_DEPTH - 1;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 400;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_ORIGIN_X;
  logic [COORD_W-1:0]   cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // Fields from bit 0: box_left, box_top, box_right, box_bottom, 24 bits each.
  logic [95:0]          s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // Fields from bit 0: cell_index[14:0], out_of_range[15].
  logic [15:0]          m_axis_tdata;

  logic signed [COORD_W-1:0] cur_org_x = '0;
  logic signed [COORD_W-1:0] cur_org_y = '0;
  logic [INV_W-1:0]          cur_inv_w = INV_RESET;
  logic [INV_W-1:0]          cur_inv_h = INV_RESET;

  result_t pending_results[$];
  result_t front_result;

  int send_gap_pct = 0;
  int rx_stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_active  = 1'b0;

  int cycle_count     = 0;
  int mismatches      = 0;
  int boxes_sent      = 0;
  int results_checked = 0;
  int outside_count   = 0;
  int settings_count  = 0;
  logic [TREE_DEPTH-1:0] levels_seen = '0;

  quadtree_morton_cell_index_core #(
    .TREE_DEPTH(TREE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Grid cell of one coordinate, or -1 when it falls outside the grid.
  function automatic int grid_cell(input logic [COORD_W-1:0] coord,
                                   input logic signed [COORD_W-1:0] org,
                                   input logic [INV_W-1:0] inv);
    longint d;
    longint c;
    d = longint'($signed(coord)) - longint'(org);
    if (d < 0) return -1;
    c = (d * longint'(inv)) >> FRAC_W;
    if (c >= (longint'(1) << FINEST)) return -1;
    return int'(c);
  endfunction

  function automatic logic [31:0] interleave_xy(input logic [15:0] x, input logic [15:0] y);
    logic [31:0] code;
    code = '0;
    for (int i = 0; i < 16; i++) begin
      code[2*i]   = x[i];
      code[2*i+1] = y[i];
    end
    return code;
  endfunction

  function automatic result_t predict_cell_index(input logic [95:0] box, output int lvl);
    int          lx, ty, rx, by;
    logic [31:0] lt, rb, diff, idx;
    result_t     res;
    lx  = grid_cell(box[23:0], cur_org_x, cur_inv_w);
    ty  = grid_cell(box[47:24], cur_org_y, cur_inv_h);
    rx  = grid_cell(box[71:48], cur_org_x, cur_inv_w);
    by  = grid_cell(box[95:72], cur_org_y, cur_inv_h);
    lvl = -1;
    if (lx < 0 || ty < 0 || rx < 0 || by < 0) begin
      res.cell_index   = '0;
      res.out_of_range = 1'b1;
      return res;
    end
    lt   = interleave_xy(lx[15:0], ty[15:0]);
    rb   = interleave_xy(rx[15:0], by[15:0]);
    diff = lt ^ rb;
    lvl  = 0;
    for (int i = 0; i < FINEST; i++) begin
      if (diff[2*i +: 2] != 2'b00) lvl = i + 1;
    end
    idx = (rb >> (2 * lvl)) + (((32'd1 << (2 * (FINEST - lvl))) - 32'd1) / 32'd3);
    res.cell_index   = idx[INDEX_W-1:0];
    res.out_of_range = 1'b0;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Long output hold-off, counted here so the sender keeps pushing until the block backs up.
  initial begin
    wait (hold_request);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word index=%0d oor=%0b",
                                m_axis_tdata[14:0], m_axis_tdata[15]));
      end else begin
        front_result = pending_results.pop_front();
        if (m_axis_tdata[14:0] !== front_result.cell_index ||
            m_axis_tdata[15] !== front_result.out_of_range) begin
          flag_mismatch($sformatf("expected index=%0d oor=%0b, got index=%0d oor=%0b",
                                  front_result.cell_index, front_result.out_of_range,
                                  m_axis_tdata[14:0], m_axis_tdata[15]));
        end
      end
    end
  end

  task automatic send_box(input logic [23:0] l, input logic [23:0] t,
                          input logic [23:0] r, input logic [23:0] b);
    logic [95:0] word;
    int          lvl;
    result_t     want;
    word = {b, r, t, l};
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = predict_cell_index(word, lvl);
    pending_results.push_back(want);
    boxes_sent++;
    if (lvl < 0) outside_count++;
    else levels_seen[lvl] = 1'b1;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [23:0] ox, input logic [23:0] oy,
                                input logic [23:0] iw, input logic [23:0] ih);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ORIGIN_X;
    cfg_data_i <= ox;
    @(posedge clk_i);
    cur_org_x  = ox;
    cfg_idx_i  <= CFG_ORIGIN_Y;
    cfg_data_i <= oy;
    @(posedge clk_i);
    cur_org_y  = oy;
    cfg_idx_i  <= CFG_INV_W;
    cfg_data_i <= iw;
    @(posedge clk_i);
    cur_inv_w  = iw;
    cfg_idx_i  <= CFG_INV_H;
    cfg_data_i <= ih;
    @(posedge clk_i);
    cur_inv_h  = ih;
    cfg_we_i   <= 1'b0;
    settings_count++;
  endtask

  // Two corners along one axis, mostly inside the grid, often sharing a cell prefix.
  task automatic pick_axis(input logic signed [23:0] org, input logic [23:0] inv,
                           output logic [23:0] lo, output logic [23:0] hi);
    longint span, d1, d2, tmp;
    if (inv == '0) span = 64'd16777215;
    else span = ((longint'(1) << (FINEST + FRAC_W)) - 1) / longint'(inv);
    if (span > 64'sd8388607 - longint'(org)) span = 64'sd8388607 - longint'(org);
    d1 = longint'($urandom_range(0, 32'(span)));
    if ($urandom_range(0, 1) == 1) begin
      d2 = d1 + longint'($urandom_range(0, 32'(span >> $urandom_range(0, 24))));
      if (d2 > span) d2 = span;
    end else begin
      d2 = longint'($urandom_range(0, 32'(span)));
    end
    if ($urandom_range(0, 3) == 0) begin
      tmp = d1;
      d1  = d2;
      d2  = tmp;
    end
    lo = 24'(longint'(org) + d1);
    hi = 24'(longint'(org) + d2);
  endtask

  task automatic send_random_box();
    logic [23:0] f [4];
    int          kind;
    kind = $urandom_range(0, 99);
    pick_axis(cur_org_x, cur_inv_w, f[0], f[2]);
    pick_axis(cur_org_y, cur_inv_h, f[1], f[3]);
    if (kind >= 88) begin
      for (int i = 0; i < 4; i++) f[i] = 24'($urandom);
    end else if (kind >= 72) begin
      f[$urandom_range(0, 3)] = 24'($urandom);
    end
    send_box(f[0], f[1], f[2], f[3]);
  endtask

  function automatic logic [23:0] random_origin();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return '0;
    if (pick < 70) return 24'($signed($urandom_range(0, 131071)) - 65536);
    return 24'($urandom);
  endfunction

  function automatic logic [23:0] random_inverse();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return INV_RESET;
    if (pick < 60) return 24'($urandom_range(256, 24'h080000));
    if (pick < 75) return 24'($urandom_range(1, 255));
    if (pick < 85) return 24'($urandom);
    if (pick < 92) return '0;
    return 24'hFFFFFF;
  endfunction

  task automatic test_default_grid();
    send_box(24'd0, 24'd0, 24'd0, 24'd0);
    send_box(24'd0, 24'd0, 24'd32767, 24'd32767);
    send_box(24'd32512, 24'd32512, 24'd32767, 24'd32767);
    send_box(24'd255, 24'd256, 24'd256, 24'd255);
    send_box(24'd0, 24'd0, 24'd32768, 24'd0);
    send_box(24'd0, 24'd0, 24'd0, 24'd32768);
    send_box(24'hFFFFFF, 24'd0, 24'd0, 24'd0);
    send_box(24'd0, 24'hFFFF00, 24'd0, 24'd0);
    send_box(24'd30000, 24'd20000, 24'd100, 24'd50);
    send_box(24'h800000, 24'h800000, 24'h800000, 24'h800000);
    send_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_box(24'd0, 24'h7FFFFF, 24'h800000, 24'd0);
    send_box(24'd16384, 24'd16384, 24'd16639, 24'd16640);
    wait_drain();
  endtask

  task automatic test_register_extremes();
    apply_settings(24'h800000, 24'h800000, 24'd1, 24'd1);
    send_box(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
    send_box(24'd0, 24'd0, 24'd0, 24'd0);
    wait_drain();
    apply_settings(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_box(24'h7FFFFE, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    wait_drain();
    apply_settings(24'd0, 24'd0, 24'd0, 24'd0);
    send_box(24'd100, 24'd5000000, 24'h7FFFFF, 24'd0);
    send_box(24'hFFFFFB, 24'd0, 24'd0, 24'd0);
    wait_drain();
    apply_settings(24'd1000, 24'hFFF830, 24'h020000, 24'h008000);
    send_box(24'd1000, 24'hFFF830, 24'd17383, 24'd63535);
    send_box(24'd17384, 24'hFFF830, 24'd1000, 24'hFFF830);
    send_box(24'd1000, 24'hFFF830, 24'd1000, 24'd63536);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int gap, input int stall, input int count);
    send_gap_pct = gap;
    rx_stall_pct <= stall;
    for (int k = 0; k < 4; k++) begin
      wait_drain();
      apply_settings(random_origin(), random_origin(), random_inverse(), random_inverse());
      repeat (count / 4) send_random_box();
    end
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    send_gap_pct = 0;
    rx_stall_pct <= 0;
    apply_settings(24'd0, 24'd0, INV_RESET, INV_RESET);
    hold_request = 1'b1;
    repeat (64) send_random_box();
    wait_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_grid();
    test_register_extremes();
    test_random_traffic(0, 0, 340);
    test_random_traffic(55, 0, 340);
    test_random_traffic(0, 55, 340);
    test_random_traffic(13, 13, 340);
    test_output_backpressure();
    wait_drain();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag_mismatch($sformatf("%0d expected words never arrived", pending_results.size()));
    end
    $display("Checked %0d result words for %0d boxes over %0d register settings.",
             results_checked, boxes_sent, settings_count);
    $display("%0d boxes fell off the grid; tree levels hit (bit per level): %b; mismatches: %0d.",
             outside_count, levels_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
